@@ hdl/psus_pkg.sv @@
`default_nettype none
package psus_pkg;

   // Mode codes as they appear on the result word.
   localparam logic [3:0] MODE_IDLE       = 4'd0;
   localparam logic [3:0] MODE_WAIT       = 4'd1;
   localparam logic [3:0] MODE_BAL        = 4'd2;
   localparam logic [3:0] MODE_POS_START1 = 4'd3;
   localparam logic [3:0] MODE_POS_RUN1   = 4'd4;
   localparam logic [3:0] MODE_POS_START2 = 4'd5;
   localparam logic [3:0] MODE_POS_RUN2   = 4'd6;
   localparam logic [3:0] MODE_NEG_START1 = 4'd7;
   localparam logic [3:0] MODE_NEG_RUN1   = 4'd8;
   localparam logic [3:0] MODE_NEG_START2 = 4'd9;
   localparam logic [3:0] MODE_NEG_RUN2   = 4'd10;

   // Phase codes inside one pulse group.
   localparam logic [1:0] PHASE_START1 = 2'd0;
   localparam logic [1:0] PHASE_RUN1   = 2'd1;
   localparam logic [1:0] PHASE_START2 = 2'd2;
   localparam logic [1:0] PHASE_RUN2   = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_PULSE_DRIVE  = 3'd0;
   localparam logic [2:0] REG_PULSE_TICKS  = 3'd1;
   localparam logic [2:0] REG_UPRIGHT_LOW  = 3'd2;
   localparam logic [2:0] REG_UPRIGHT_HIGH = 3'd3;
   localparam logic [2:0] REG_FAULT_LOW    = 3'd4;
   localparam logic [2:0] REG_FAULT_HIGH   = 3'd5;
   localparam logic [2:0] REG_SAMPLE_GAP   = 3'd6;
   localparam logic [2:0] REG_PEAK_MARGIN  = 3'd7;

   localparam logic [6:0] DRIVE_MAX = 7'd100;

   typedef struct packed {
      logic [6:0]  pulse_drive;
      logic [9:0]  pulse_ticks;
      logic [11:0] upright_low;
      logic [11:0] upright_high;
      logic [11:0] fault_low;
      logic [11:0] fault_high;
      logic [5:0]  sample_gap;
      logic [7:0]  peak_margin;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic [11:0] angle;
   } req_type;

   typedef struct packed {
      logic              drive_write;
      logic signed [7:0] drive_value;
      logic              loops_reset;
      logic              outer_strobe;
      logic              inner_strobe;
      logic              fault;
      logic [3:0]        mode;
   } rsp_type;

endpackage
`default_nettype wire

@@ hdl/psus_ifs.sv @@
`default_nettype none
interface psus_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [11:0] angle;
   modport source (output valid, output func, output angle, input ready);
   modport sink (input valid, input func, input angle, output ready);
endinterface

interface psus_rsp_if;
   logic              valid;
   logic              ready;
   logic              drive_write;
   logic signed [7:0] drive_value;
   logic              loops_reset;
   logic              outer_strobe;
   logic              inner_strobe;
   logic              fault;
   logic [3:0]        mode;
   modport source (output valid, output drive_write, output drive_value, output loops_reset,
                   output outer_strobe, output inner_strobe, output fault, output mode,
                   input ready);
   modport sink (input valid, input drive_write, input drive_value, input loops_reset,
                 input outer_strobe, input inner_strobe, input fault, input mode,
                 output ready);
endinterface

interface psus_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [11:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hdl/psus_csr.sv @@
`default_nettype none
// Configuration register file; writes are always taken.
module psus_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [2:0]        wr_index,
   input  wire logic [11:0]       wr_data,
   output      psus_pkg::cfg_type cfg
);

   psus_pkg::cfg_type cfg_ff;
   psus_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            psus_pkg::REG_PULSE_DRIVE:  cfg_in.pulse_drive  = wr_data[6:0];
            psus_pkg::REG_PULSE_TICKS:  cfg_in.pulse_ticks  = wr_data[9:0];
            psus_pkg::REG_UPRIGHT_LOW:  cfg_in.upright_low  = wr_data;
            psus_pkg::REG_UPRIGHT_HIGH: cfg_in.upright_high = wr_data;
            psus_pkg::REG_FAULT_LOW:    cfg_in.fault_low    = wr_data;
            psus_pkg::REG_FAULT_HIGH:   cfg_in.fault_high   = wr_data;
            psus_pkg::REG_SAMPLE_GAP:   cfg_in.sample_gap   = wr_data[5:0];
            psus_pkg::REG_PEAK_MARGIN:  cfg_in.peak_margin  = wr_data[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_drive  <= 7'd40;
         cfg_ff.pulse_ticks  <= 10'd90;
         cfg_ff.upright_low  <= 12'd1700;
         cfg_ff.upright_high <= 12'd2300;
         cfg_ff.fault_low    <= 12'd1000;
         cfg_ff.fault_high   <= 12'd3000;
         cfg_ff.sample_gap   <= 6'd40;
         cfg_ff.peak_margin  <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ hdl/psus_core.sv @@
`default_nettype none
// Mode state, counters and angle history, plus the next-state logic for one word.
module psus_core #(
   parameter int OUTER_DIV = 50,
   parameter int INNER_DIV = 5
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire psus_pkg::req_type item,
   input  wire psus_pkg::cfg_type cfg,
   output      psus_pkg::rsp_type result
);

   localparam int OUTER_W = $clog2(OUTER_DIV + 1);
   localparam int INNER_W = $clog2(INNER_DIV + 1);

   logic [3:0]         mode_ff,   mode_in;
   logic [5:0]         sample_ff, sample_in;
   logic [OUTER_W-1:0] outer_ff,  outer_in;
   logic [INNER_W-1:0] inner_ff,  inner_in;
   logic [9:0]         timer_ff,  timer_in;
   logic [11:0]        hist_ff [3];
   logic [11:0]        hist_in [3];

   logic [6:0]  mag;
   logic        pulse_neg_group;
   logic [3:0]  phase_full;
   logic [1:0]  phase;
   logic        drive_neg;
   logic [9:0]  timer_dec;
   logic [11:0] a0, a1, a2;
   logic [12:0] a0_m, a1_m, a2_m;
   logic        bal_hit, pos_hit, neg_hit;
   psus_pkg::rsp_type res;

   assign mag = (cfg.pulse_drive > psus_pkg::DRIVE_MAX) ? psus_pkg::DRIVE_MAX : cfg.pulse_drive;
   assign pulse_neg_group = (mode_ff >= psus_pkg::MODE_NEG_START1);
   assign phase_full = pulse_neg_group ? (mode_ff - psus_pkg::MODE_NEG_START1)
                                       : (mode_ff - psus_pkg::MODE_POS_START1);
   assign phase = phase_full[1:0];
   assign drive_neg = pulse_neg_group ^ phase[1];
   assign timer_dec = timer_ff - 10'd1;

   // Sample window after the shift: a0 newest.
   assign a0 = item.angle;
   assign a1 = hist_ff[0];
   assign a2 = hist_ff[1];
   assign a0_m = {1'b0, a0} + {5'd0, cfg.peak_margin};
   assign a1_m = {1'b0, a1} + {5'd0, cfg.peak_margin};
   assign a2_m = {1'b0, a2} + {5'd0, cfg.peak_margin};

   assign bal_hit = (a0 > cfg.upright_low) && (a0 < cfg.upright_high) &&
                    (a1 > cfg.upright_low) && (a1 < cfg.upright_high);
   assign pos_hit = (a0 >= cfg.upright_high) && (a1 >= cfg.upright_high) &&
                    (a2 >= cfg.upright_high) &&
                    (a1_m < {1'b0, a0}) && (a1_m < {1'b0, a2});
   assign neg_hit = (a0 <= cfg.upright_low) && (a1 <= cfg.upright_low) &&
                    (a2 <= cfg.upright_low) &&
                    ({1'b0, a1} > a0_m) && ({1'b0, a1} > a2_m);

   always_comb begin
      mode_in   = mode_ff;
      sample_in = sample_ff;
      outer_in  = outer_ff;
      inner_in  = inner_ff;
      timer_in  = timer_ff;
      hist_in   = hist_ff;
      res       = '0;
      if (item.func) begin
         mode_in = (mode_ff == psus_pkg::MODE_IDLE) ? psus_pkg::MODE_POS_START2
                                                    : psus_pkg::MODE_IDLE;
      end else begin
         case (mode_ff)
            psus_pkg::MODE_WAIT: begin
               if (sample_ff < cfg.sample_gap) begin
                  sample_in = sample_ff + 6'd1;
               end else begin
                  sample_in  = '0;
                  hist_in[2] = hist_ff[1];
                  hist_in[1] = hist_ff[0];
                  hist_in[0] = item.angle;
                  // Later tests take priority: negative over positive over balance.
                  if (bal_hit) begin
                     mode_in         = psus_pkg::MODE_BAL;
                     res.loops_reset = 1'b1;
                  end
                  if (pos_hit) begin
                     mode_in = psus_pkg::MODE_POS_START1;
                  end
                  if (neg_hit) begin
                     mode_in = psus_pkg::MODE_NEG_START1;
                  end
               end
            end
            psus_pkg::MODE_BAL: begin
               if (outer_ff >= OUTER_W'(OUTER_DIV)) begin
                  outer_in         = '0;
                  res.outer_strobe = 1'b1;
               end else begin
                  outer_in = outer_ff + OUTER_W'(1);
               end
               if (inner_ff >= INNER_W'(INNER_DIV)) begin
                  inner_in         = '0;
                  res.inner_strobe = 1'b1;
                  if ((item.angle > cfg.fault_high) || (item.angle < cfg.fault_low)) begin
                     res.fault = 1'b1;
                     mode_in   = psus_pkg::MODE_IDLE;
                  end
               end else begin
                  inner_in = inner_ff + INNER_W'(1);
               end
            end
            psus_pkg::MODE_POS_START1, psus_pkg::MODE_POS_RUN1,
            psus_pkg::MODE_POS_START2, psus_pkg::MODE_POS_RUN2,
            psus_pkg::MODE_NEG_START1, psus_pkg::MODE_NEG_RUN1,
            psus_pkg::MODE_NEG_START2, psus_pkg::MODE_NEG_RUN2: begin
               if ((phase == psus_pkg::PHASE_START1) || (phase == psus_pkg::PHASE_START2)) begin
                  res.drive_write = 1'b1;
                  res.drive_value = drive_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
                  timer_in        = cfg.pulse_ticks;
                  mode_in         = mode_ff + 4'd1;
               end else begin
                  timer_in = timer_dec;
                  if (timer_dec == 10'd0) begin
                     if (phase == psus_pkg::PHASE_RUN1) begin
                        mode_in = mode_ff + 4'd1;
                     end else begin
                        res.drive_write = 1'b1;
                        mode_in         = psus_pkg::MODE_WAIT;
                     end
                  end
               end
            end
            default: begin
               // Idle, and any code outside the mode list, behaves as idle.
               mode_in         = psus_pkg::MODE_IDLE;
               res.drive_write = 1'b1;
            end
         endcase
      end
      res.mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= psus_pkg::MODE_IDLE;
         sample_ff <= '0;
         outer_ff  <= '0;
         inner_ff  <= '0;
         timer_ff  <= '0;
         hist_ff   <= '{default: '0};
      end else if (step_en) begin
         mode_ff   <= mode_in;
         sample_ff <= sample_in;
         outer_ff  <= outer_in;
         inner_ff  <= inner_in;
         timer_ff  <= timer_in;
         hist_ff   <= hist_in;
      end
   end

   assign result = res;

endmodule
`default_nettype wire

@@ hdl/pendulum_swing_up_sequencer.sv @@
`default_nettype none
// Channel  Direction  Word contents
// req_ch   in         func, angle
// rsp_ch   out        drive_write, drive_value, loops_reset, outer_strobe,
//                     inner_strobe, fault, mode
// csr_ch   in         index, wdata (register write, always ready)
//
// Every accepted word gives exactly one result word, which passes first through the input
// register and then through the result register.
// A new word can be accepted every cycle unless both registers are full and stalled.
// Reset is synchronous and active high; it puts the block in idle with all counters,
// the angle history and the configuration registers at their documented defaults.
// A stalled result side fills both registers before req_ch.ready drops.
module pendulum_swing_up_sequencer #(
   parameter int OUTER_DIV = 50,
   parameter int INNER_DIV = 5
) (
   input wire logic   clock,
   input wire logic   reset,
   psus_req_if.sink   req_ch,
   psus_rsp_if.source rsp_ch,
   psus_csr_if.sink   csr_ch
);

   psus_pkg::cfg_type cfg;
   psus_pkg::req_type item_ff;
   psus_pkg::rsp_type result;
   psus_pkg::rsp_type out_ff;
   logic              item_valid_ff, item_valid_in;
   logic              out_valid_ff,  out_valid_in;
   logic              out_free;
   logic              step_en;
   logic              req_take;

   // The result register can be loaded when it is empty or its word leaves this cycle.
   assign out_free = !out_valid_ff || rsp_ch.ready;
   // The held word is worked on exactly when it can move into the result register.
   assign step_en  = item_valid_ff && out_free;
   assign req_ch.ready = !item_valid_ff || step_en;
   assign req_take = req_ch.valid && req_ch.ready;

   assign item_valid_in = req_take || (item_valid_ff && !step_en);
   assign out_valid_in  = step_en || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func  <= req_ch.func;
         item_ff.angle <= req_ch.angle;
      end
      if (step_en) begin
         out_ff <= result;
      end
   end

   // Configuration writes are taken on every cycle.
   assign csr_ch.ready = 1'b1;

   psus_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.wdata),
      .cfg      (cfg)
   );

   psus_core #(
      .OUTER_DIV (OUTER_DIV),
      .INNER_DIV (INNER_DIV)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.drive_write  = out_ff.drive_write;
   assign rsp_ch.drive_value  = out_ff.drive_value;
   assign rsp_ch.loops_reset  = out_ff.loops_reset;
   assign rsp_ch.outer_strobe = out_ff.outer_strobe;
   assign rsp_ch.inner_strobe = out_ff.inner_strobe;
   assign rsp_ch.fault        = out_ff.fault;
   assign rsp_ch.mode         = out_ff.mode;

endmodule
`default_nettype wire

@@ hdl/psus_checker.sv @@
`default_nettype none
module psus_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              drive_write,
   input wire logic signed [7:0] drive_value,
   input wire logic              loops_reset,
   input wire logic              fault,
   input wire logic [3:0]        mode
);

   // A fault always sends the block back to idle.
   a_fault_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && fault) |-> (mode == psus_pkg::MODE_IDLE))
      else $error("fault reported outside idle");

   // Loop reset only comes with the hand-over from waiting.
   a_loops_reset_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && loops_reset) |->
         (mode == psus_pkg::MODE_BAL || mode == psus_pkg::MODE_POS_START1 ||
          mode == psus_pkg::MODE_NEG_START1))
      else $error("loop reset with unexpected mode");

   // No drive value is shown without a drive command.
   a_drive_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !drive_write) |-> (drive_value == 8'sd0))
      else $error("drive value without drive write");

   // Magnitude stays within the saturated range.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (drive_value <= 8'sd100 && drive_value >= -8'sd100))
      else $error("drive value out of range");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(mode) && $stable(drive_value)))
      else $error("stalled result changed");

endmodule

bind pendulum_swing_up_sequencer psus_checker u_psus_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .drive_write (rsp_ch.drive_write),
   .drive_value (rsp_ch.drive_value),
   .loops_reset (rsp_ch.loops_reset),
   .fault       (rsp_ch.fault),
   .mode        (rsp_ch.mode)
);
`default_nettype wire
